/* hw/rtl/xmsi_pkg.sv */
// Shared types, byte codes and markup kind codes for the XML markup start indexer.
package xmsi_pkg;

   localparam int TEXT_BYTE_WIDTH  = 8;
   localparam int MARKUP_POS_WIDTH = 32;
   localparam int MARKUP_KIND_WIDTH = 3;

   // Byte codes the scanner looks for
   localparam logic [TEXT_BYTE_WIDTH-1:0] CHAR_LT     = 8'h3C; // '<'
   localparam logic [TEXT_BYTE_WIDTH-1:0] CHAR_SLASH  = 8'h2F; // '/'
   localparam logic [TEXT_BYTE_WIDTH-1:0] CHAR_QUEST  = 8'h3F; // '?'
   localparam logic [TEXT_BYTE_WIDTH-1:0] CHAR_BANG   = 8'h21; // '!'
   localparam logic [TEXT_BYTE_WIDTH-1:0] CHAR_LBRACK = 8'h5B; // '['
   localparam logic [TEXT_BYTE_WIDTH-1:0] CHAR_C      = 8'h43; // 'C'
   localparam logic [TEXT_BYTE_WIDTH-1:0] CHAR_D      = 8'h44; // 'D'
   localparam logic [TEXT_BYTE_WIDTH-1:0] CHAR_A      = 8'h41; // 'A'
   localparam logic [TEXT_BYTE_WIDTH-1:0] CHAR_T      = 8'h54; // 'T'
   localparam logic [TEXT_BYTE_WIDTH-1:0] CHAR_DASH   = 8'h2D; // '-'
   localparam logic [TEXT_BYTE_WIDTH-1:0] CHAR_RBRACK = 8'h5D; // ']'
   localparam logic [TEXT_BYTE_WIDTH-1:0] CHAR_GT     = 8'h3E; // '>'

   // Length of the "CDATA[" tail after "<!["
   localparam logic [2:0] CDATA_TAIL_LEN = 3'd6;

   // Markup kind codes
   localparam logic [MARKUP_KIND_WIDTH-1:0] KIND_START   = 3'd0;
   localparam logic [MARKUP_KIND_WIDTH-1:0] KIND_END     = 3'd1;
   localparam logic [MARKUP_KIND_WIDTH-1:0] KIND_PI      = 3'd2;
   localparam logic [MARKUP_KIND_WIDTH-1:0] KIND_CDATA   = 3'd3;
   localparam logic [MARKUP_KIND_WIDTH-1:0] KIND_COMMENT = 3'd4;

   // One result record
   typedef struct packed {
      logic [MARKUP_POS_WIDTH-1:0]  markup_position;
      logic [MARKUP_KIND_WIDTH-1:0] markup_kind;
      logic                         run_last;
   } rec_type;

   // Records produced by one scanned byte, packed to the front
   typedef struct packed {
      logic [1:0] cnt;
      rec_type    rec0;
      rec_type    rec1;
   } push_type;

   // Expected byte of the CDATA tail at each match index
   function automatic logic [TEXT_BYTE_WIDTH-1:0] cdata_tail(input logic [2:0] idx);
      logic [TEXT_BYTE_WIDTH-1:0] ch;
      unique case (idx)
         3'd0: ch = CHAR_C;
         3'd1: ch = CHAR_D;
         3'd2: ch = CHAR_A;
         3'd3: ch = CHAR_T;
         3'd4: ch = CHAR_A;
         3'd5: ch = CHAR_LBRACK;
         default: ch = '0;
      endcase
      return ch;
   endfunction

endpackage

/* hw/rtl/xmsi_if.sv */
// Valid/ready channel interfaces for the text byte input and the markup record output.
interface xmsi_req_if;
   import xmsi_pkg::*;

   logic                       valid;
   logic                       ready;
   logic [TEXT_BYTE_WIDTH-1:0] text_byte;
   logic                       stream_end;

   modport source (output valid, text_byte, stream_end, input ready);
   modport sink   (input valid, text_byte, stream_end, output ready);
endinterface

interface xmsi_rsp_if;
   import xmsi_pkg::*;

   logic                         valid;
   logic                         ready;
   logic [MARKUP_POS_WIDTH-1:0]  markup_position;
   logic [MARKUP_KIND_WIDTH-1:0] markup_kind;
   logic                         run_last;

   modport source (output valid, markup_position, markup_kind, run_last, input ready);
   modport sink   (input valid, markup_position, markup_kind, run_last, output ready);
endinterface

/* hw/rtl/xmsi_scan.sv */
// Input byte register, scanner state and the per-byte markup classification step.
module xmsi_scan #(
   parameter int POSITION_BITS = 32
) (
   input  logic               clock,
   input  logic               reset,
   xmsi_req_if.sink           req_chan,
   input  logic [1:0]         free_slots,
   output xmsi_pkg::push_type push
);
   import xmsi_pkg::*;

   typedef enum logic [2:0] {
      MODE_IDLE,
      MODE_LT,
      MODE_BANG,
      MODE_CDPRE,
      MODE_DASH1,
      MODE_PI,
      MODE_CDATA,
      MODE_COMMENT
   } mode_type;

   localparam logic [POSITION_BITS-1:0] POS_MAX = {POSITION_BITS{1'b1}};

   // Input register
   logic                       in_vld_ff, in_vld_in;
   logic [TEXT_BYTE_WIDTH-1:0] in_byte_ff;
   logic                       in_end_ff;

   // Scanner state
   mode_type                   mode_ff, mode_in;
   logic [2:0]                 pfx_ff, pfx_in;
   logic [1:0]                 run_ff, run_in;
   logic [POSITION_BITS-1:0]   bpos_ff, bpos_in;
   logic [POSITION_BITS-1:0]   opos_ff, opos_in;

   // Step signals
   logic [TEXT_BYTE_WIDTH-1:0] c;
   logic [POSITION_BITS-1:0]   pos_inc;
   mode_type                   mode_s;
   logic [2:0]                 pfx_s;
   logic [1:0]                 run_s;
   logic [POSITION_BITS-1:0]   opos_s;
   logic                       emit_a;
   logic [MARKUP_KIND_WIDTH-1:0] kind_a;
   logic                       rescan;
   logic                       flush;
   logic [1:0]                 cnt_raw;
   rec_type                    rec_a, rec_b;
   logic                       fire;
   logic                       req_xfer;

   assign c       = in_byte_ff;
   assign pos_inc = (bpos_ff != POS_MAX) ? bpos_ff + POSITION_BITS'(1) : bpos_ff;

   // Classify one byte against the current scan mode
   always_comb begin
      mode_s = mode_ff;
      pfx_s  = pfx_ff;
      run_s  = run_ff;
      opos_s = opos_ff;
      emit_a = 1'b0;
      kind_a = KIND_START;
      rescan = 1'b0;
      unique case (mode_ff)
         MODE_LT: begin
            priority if (c == CHAR_SLASH) begin
               emit_a = 1'b1;
               kind_a = KIND_END;
               mode_s = MODE_IDLE;
            end else if (c == CHAR_QUEST) begin
               emit_a = 1'b1;
               kind_a = KIND_PI;
               mode_s = MODE_PI;
               run_s  = 2'd0;
            end else if (c == CHAR_BANG) begin
               mode_s = MODE_BANG;
            end else begin
               emit_a = 1'b1;
               rescan = 1'b1;
            end
         end
         MODE_BANG: begin
            priority if (c == CHAR_LBRACK) begin
               mode_s = MODE_CDPRE;
               pfx_s  = 3'd0;
            end else if (c == CHAR_DASH) begin
               mode_s = MODE_DASH1;
            end else begin
               emit_a = 1'b1;
               rescan = 1'b1;
            end
         end
         MODE_CDPRE: begin
            if (pfx_ff < CDATA_TAIL_LEN && c == cdata_tail(pfx_ff)) begin
               if (pfx_ff == CDATA_TAIL_LEN - 3'd1) begin
                  emit_a = 1'b1;
                  kind_a = KIND_CDATA;
                  mode_s = MODE_CDATA;
                  pfx_s  = 3'd0;
                  run_s  = 2'd0;
               end else begin
                  pfx_s = pfx_ff + 3'd1;
               end
            end else begin
               emit_a = 1'b1;
               rescan = 1'b1;
            end
         end
         MODE_DASH1: begin
            if (c == CHAR_DASH) begin
               emit_a = 1'b1;
               kind_a = KIND_COMMENT;
               mode_s = MODE_COMMENT;
               run_s  = 2'd2;
            end else begin
               emit_a = 1'b1;
               rescan = 1'b1;
            end
         end
         MODE_PI: begin
            if (c == CHAR_GT && run_ff == 2'd1) begin
               mode_s = MODE_IDLE;
               run_s  = 2'd0;
            end else begin
               run_s = (c == CHAR_QUEST) ? 2'd1 : 2'd0;
            end
         end
         MODE_CDATA, MODE_COMMENT: begin
            priority if (c == CHAR_GT && run_ff >= 2'd2) begin
               mode_s = MODE_IDLE;
               run_s  = 2'd0;
            end else if (c == ((mode_ff == MODE_CDATA) ? CHAR_RBRACK : CHAR_DASH)) begin
               if (run_ff < 2'd2) run_s = run_ff + 2'd1;
            end else begin
               run_s = 2'd0;
            end
         end
         default: begin
            mode_s = MODE_IDLE;
            pfx_s  = 3'd0;
            run_s  = 2'd0;
            rescan = 1'b1;
         end
      endcase
      // Failed lookahead and idle bytes: scan as outside markup
      if (rescan) begin
         mode_s = MODE_IDLE;
         pfx_s  = 3'd0;
         if (c == CHAR_LT) begin
            mode_s = MODE_LT;
            opos_s = pos_inc;
         end
      end
   end

   // Settle a pending '<' at end of stream
   assign flush = in_end_ff && (mode_s == MODE_LT || mode_s == MODE_BANG ||
                                mode_s == MODE_CDPRE || mode_s == MODE_DASH1);

   assign cnt_raw = {1'b0, emit_a} + {1'b0, flush};

   // Build records; the first one uses the '<' held before this byte
   always_comb begin
      rec_a.markup_position = MARKUP_POS_WIDTH'(opos_ff);
      rec_a.markup_kind     = kind_a;
      rec_a.run_last        = !flush;
      rec_b.markup_position = MARKUP_POS_WIDTH'(opos_s);
      rec_b.markup_kind     = KIND_START;
      rec_b.run_last        = 1'b1;
   end

   assign fire = in_vld_ff && (cnt_raw <= free_slots);

   always_comb begin
      push.cnt  = fire ? cnt_raw : 2'd0;
      push.rec0 = emit_a ? rec_a : rec_b;
      push.rec1 = rec_b;
   end

   // Next state: end of stream returns the scanner to its reset state
   always_comb begin
      if (in_end_ff) begin
         mode_in = MODE_IDLE;
         pfx_in  = 3'd0;
         run_in  = 2'd0;
         bpos_in = '0;
         opos_in = '0;
      end else begin
         mode_in = mode_s;
         pfx_in  = pfx_s;
         run_in  = run_s;
         bpos_in = pos_inc;
         opos_in = opos_s;
      end
   end

   // Input register handshake: take a byte when the register is empty or the held one moves on
   assign req_chan.ready = !in_vld_ff || fire;
   assign req_xfer       = req_chan.valid && req_chan.ready;
   assign in_vld_in      = req_xfer || (in_vld_ff && !fire);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
         mode_ff   <= MODE_IDLE;
         pfx_ff    <= 3'd0;
         run_ff    <= 2'd0;
         bpos_ff   <= '0;
         opos_ff   <= '0;
      end else begin
         in_vld_ff <= in_vld_in;
         if (fire) begin
            mode_ff <= mode_in;
            pfx_ff  <= pfx_in;
            run_ff  <= run_in;
            bpos_ff <= bpos_in;
            opos_ff <= opos_in;
         end
      end
   end

   // Hold the payload of a transfer
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         in_byte_ff <= req_chan.text_byte;
         in_end_ff  <= req_chan.stream_end;
      end
   end

endmodule

/* hw/rtl/xmsi_rsp_queue.sv */
// Two-entry result register that takes up to two records per cycle and sends one.
module xmsi_rsp_queue (
   input  logic               clock,
   input  logic               reset,
   input  xmsi_pkg::push_type push,
   output logic [1:0]         free_slots,
   xmsi_rsp_if.source         rsp_chan
);
   import xmsi_pkg::*;

   rec_type    slot_ff [2];
   rec_type    slot_in [2];
   logic [1:0] vld_ff, vld_in;

   logic       pop;
   rec_type    keep0, keep1;
   logic       keep_vld0, keep_vld1;

   assign pop = vld_ff[0] && rsp_chan.ready;

   // Shift out the sent record
   always_comb begin
      keep0     = pop ? slot_ff[1] : slot_ff[0];
      keep_vld0 = pop ? vld_ff[1] : vld_ff[0];
      keep1     = slot_ff[1];
      keep_vld1 = pop ? 1'b0 : vld_ff[1];
   end

   assign free_slots = 2'd2 - ({1'b0, keep_vld0} + {1'b0, keep_vld1});

   // Append new records behind the ones kept
   always_comb begin
      slot_in[0] = keep0;
      slot_in[1] = keep1;
      vld_in     = {keep_vld1, keep_vld0};
      priority if (!keep_vld0) begin
         slot_in[0] = push.rec0;
         slot_in[1] = push.rec1;
         vld_in     = {push.cnt == 2'd2, push.cnt != 2'd0};
      end else if (!keep_vld1) begin
         slot_in[1] = push.rec0;
         vld_in     = {push.cnt != 2'd0, 1'b1};
      end else begin
         vld_in = 2'b11;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 2'b00;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff[0] <= slot_in[0];
      slot_ff[1] <= slot_in[1];
   end

   assign rsp_chan.valid           = vld_ff[0];
   assign rsp_chan.markup_position = slot_ff[0].markup_position;
   assign rsp_chan.markup_kind     = slot_ff[0].markup_kind;
   assign rsp_chan.run_last        = slot_ff[0].run_last;

endmodule

/* hw/rtl/xml_markup_start_indexer.sv */
// XML markup start indexer: one text byte in, zero to two markup records out.
// Each accepted byte is held in the input register; its records are written into the
//   result register and shown from there.
// Throughput: one byte per cycle while the result register has room for the byte's
//   records; the output port of the result register sends a single record at a time.
// Reset (synchronous, active high) empties both registers and returns the scanner
//   to idle with the position counter at zero; a stream-end byte also does the latter.
module xml_markup_start_indexer #(
   parameter int POSITION_BITS = 32
) (
   input logic      clock,
   input logic      reset,
   xmsi_req_if.sink   req_chan,
   xmsi_rsp_if.source rsp_chan
);
   import xmsi_pkg::*;

   push_type   push;
   logic [1:0] free_slots;

   // Scan bytes in order
   xmsi_scan #(
      .POSITION_BITS(POSITION_BITS)
   ) u_scan (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .free_slots (free_slots),
      .push       (push)
   );

   // Hold and send records
   xmsi_rsp_queue u_rsp_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .free_slots (free_slots),
      .rsp_chan   (rsp_chan)
   );

   // Never push more records than the result register can take
   a_push_fits: assert property (@(posedge clock) disable iff (reset)
      push.cnt <= free_slots)
      else $error("record push overflows result register");

   // A record that is not last of its byte is followed by another one
   a_run_continues: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.ready && !rsp_chan.run_last |=> rsp_chan.valid)
      else $error("record run broken after a non-last record");

   // Only defined kinds leave the block
   a_kind_range: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> rsp_chan.markup_kind <= KIND_COMMENT)
      else $error("undefined markup kind sent");

   // Nothing is shown right after reset
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_chan.valid)
      else $error("record valid after reset");

endmodule

/* sim/xmsi_markup_checker.sv */
`timescale 1ns / 100ps
// Markup record predictor and scoreboard for the XML markup start indexer.
module xmsi_markup_checker
   import xmsi_pkg::*;
#(
   parameter int POSITION_BITS = 32
) (
   input  logic clock,
   input  logic reset,
   xmsi_req_if  req_mon,
   xmsi_rsp_if  rsp_mon,
   output int   fail_count,
   output int   pending
);

   typedef enum logic [3:0] {
      SCAN_IDLE,
      SCAN_LT,
      SCAN_BANG,
      SCAN_CDPRE,
      SCAN_DASH1,
      SCAN_PI,
      SCAN_CDATA,
      SCAN_COMMENT
   } scan_mode_type;

   // "CDATA[" packed low byte first
   localparam logic [47:0] CDATA_TAIL = {CHAR_LBRACK, CHAR_A, CHAR_T, CHAR_A, CHAR_D, CHAR_C};

   scan_mode_type            scan_mode = SCAN_IDLE;
   logic [2:0]               tail_idx  = '0;
   logic [1:0]               close_run = '0;
   logic [POSITION_BITS-1:0] byte_pos  = '0;
   logic [POSITION_BITS-1:0] open_pos  = '0;
   rec_type                  markup_q[$];

   function automatic rec_type at_open(input logic [MARKUP_KIND_WIDTH-1:0] kind);
      rec_type rec;
      rec.markup_position = MARKUP_POS_WIDTH'(open_pos);
      rec.markup_kind     = kind;
      rec.run_last        = 1'b0;
      return rec;
   endfunction

   task automatic clear_scan();
      scan_mode = SCAN_IDLE;
      tail_idx  = '0;
      close_run = '0;
      byte_pos  = '0;
      open_pos  = '0;
   endtask

   // Advance the scanner by one text byte and queue the records it settles
   task automatic index_byte(input logic [7:0] ch, input logic fin);
      rec_type    recs[2];
      int         n;
      logic       prefix_broken;
      logic [7:0] close_mark;
      n             = 0;
      prefix_broken = 1'b0;
      if (byte_pos != '1) byte_pos = byte_pos + POSITION_BITS'(1);

      case (scan_mode)
         SCAN_LT: begin
            if (ch == CHAR_SLASH) begin
               recs[n] = at_open(KIND_END);
               n++;
               scan_mode = SCAN_IDLE;
            end else if (ch == CHAR_QUEST) begin
               recs[n] = at_open(KIND_PI);
               n++;
               scan_mode = SCAN_PI;
               close_run = '0;
            end else if (ch == CHAR_BANG) begin
               scan_mode = SCAN_BANG;
            end else begin
               prefix_broken = 1'b1;
            end
         end
         SCAN_BANG: begin
            if (ch == CHAR_LBRACK) begin
               scan_mode = SCAN_CDPRE;
               tail_idx  = '0;
            end else if (ch == CHAR_DASH) begin
               scan_mode = SCAN_DASH1;
            end else begin
               prefix_broken = 1'b1;
            end
         end
         SCAN_CDPRE: begin
            if (tail_idx < CDATA_TAIL_LEN && ch == CDATA_TAIL[tail_idx*8 +: 8]) begin
               tail_idx = tail_idx + 3'd1;
               if (tail_idx == CDATA_TAIL_LEN) begin
                  recs[n] = at_open(KIND_CDATA);
                  n++;
                  scan_mode = SCAN_CDATA;
                  tail_idx  = '0;
                  close_run = '0;
               end
            end else begin
               prefix_broken = 1'b1;
            end
         end
         SCAN_DASH1: begin
            if (ch == CHAR_DASH) begin
               recs[n] = at_open(KIND_COMMENT);
               n++;
               scan_mode = SCAN_COMMENT;
               // opener dashes already count toward the close
               close_run = 2'd2;
            end else begin
               prefix_broken = 1'b1;
            end
         end
         SCAN_PI: begin
            // the '?' of the opener never counts toward "?>"
            if (ch == CHAR_GT && close_run == 2'd1) begin
               scan_mode = SCAN_IDLE;
               close_run = '0;
            end else begin
               close_run = (ch == CHAR_QUEST) ? 2'd1 : 2'd0;
            end
         end
         SCAN_CDATA, SCAN_COMMENT: begin
            close_mark = (scan_mode == SCAN_CDATA) ? CHAR_RBRACK : CHAR_DASH;
            if (ch == CHAR_GT && close_run >= 2'd2) begin
               scan_mode = SCAN_IDLE;
               close_run = '0;
            end else if (ch == close_mark) begin
               if (close_run < 2'd2) close_run = close_run + 2'd1;
            end else begin
               close_run = '0;
            end
         end
         default: begin
            scan_mode = SCAN_IDLE;
            tail_idx  = '0;
            close_run = '0;
            if (ch == CHAR_LT) begin
               scan_mode = SCAN_LT;
               open_pos  = byte_pos;
            end
         end
      endcase

      // Failed lookahead: the '<' was a plain tag, rescan this byte from idle
      if (prefix_broken) begin
         recs[n] = at_open(KIND_START);
         n++;
         scan_mode = SCAN_IDLE;
         tail_idx  = '0;
         if (ch == CHAR_LT) begin
            scan_mode = SCAN_LT;
            open_pos  = byte_pos;
         end
      end

      // Stream end settles an undecided '<' as a start tag, then starts over
      if (fin) begin
         if (scan_mode inside {SCAN_LT, SCAN_BANG, SCAN_CDPRE, SCAN_DASH1}) begin
            recs[n] = at_open(KIND_START);
            n++;
         end
         clear_scan();
      end

      for (int i = 0; i < n; i++) begin
         if (i == n - 1) recs[i].run_last = 1'b1;
         markup_q.push_back(recs[i]);
      end
   endtask

   task automatic flag_field(input string field, input logic [31:0] want,
                             input logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
         fail_count++;
      end
   endtask

   // Predict on each byte transfer, compare on each record transfer
   always @(posedge clock) begin
      rec_type want;
      if (reset) begin
         clear_scan();
         markup_q.delete();
      end else begin
         if (req_mon.valid && req_mon.ready)
            index_byte(req_mon.text_byte, req_mon.stream_end);
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (markup_q.size() == 0) begin
               $display("%0t: no record expected, got position %0d kind %0d last %0d",
                        $time, rsp_mon.markup_position, rsp_mon.markup_kind,
                        rsp_mon.run_last);
               fail_count++;
            end else begin
               want = markup_q.pop_front();
               flag_field("markup_position", want.markup_position, rsp_mon.markup_position);
               flag_field("markup_kind", 32'(want.markup_kind), 32'(rsp_mon.markup_kind));
               flag_field("run_last", 32'(want.run_last), 32'(rsp_mon.run_last));
            end
         end
      end
      pending <= markup_q.size();
   end

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 100ps
// Top of the XML markup start indexer testbench: clock, reset, byte stimulus and verdict.
module tb_top;
   import xmsi_pkg::*;

   localparam int POS_BITS       = 32;
   localparam int RANDOM_BYTES   = 1750;
   localparam int HOLD_OFF_LEN   = 300;
   localparam int DRAIN_CYCLES   = 8;
   localparam int TIME_LIMIT_NS  = 2_000_000;

   typedef struct packed {
      logic [TEXT_BYTE_WIDTH-1:0] text_byte;
      logic                       stream_end;
   } text_item_type;

   logic          clock       = 1'b0;
   logic          reset       = 1'b1;
   logic          hold_off    = 1'b0;
   logic          hold_off_go = 1'b0;
   int            send_idle_pct;
   int            stall_pct;
   int            fail_count;
   int            pending;
   text_item_type text_q[$];

   xmsi_req_if req_if ();
   xmsi_rsp_if rsp_if ();

   xml_markup_start_indexer #(
      .POSITION_BITS (POS_BITS)
   ) i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   xmsi_markup_checker #(
      .POSITION_BITS (POS_BITS)
   ) i_markup_chk (
      .clock      (clock),
      .reset      (reset),
      .req_mon    (req_if),
      .rsp_mon    (rsp_if),
      .fail_count (fail_count),
      .pending    (pending)
   );

   always #5 clock = ~clock;

   // Hard stop in case the block hangs
   initial begin
      #(TIME_LIMIT_NS);
      $display("[FAIL] regression broken");
      $finish;
   end

   // Long receiver hold-off so the block backs up into its input
   initial begin
      wait (hold_off_go);
      @(posedge clock);
      hold_off <= 1'b1;
      repeat (HOLD_OFF_LEN) @(posedge clock);
      hold_off <= 1'b0;
   end

   // Random result back-pressure
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= !hold_off && ($urandom_range(99) >= stall_pct);
      end
   end

   task automatic add_byte(input logic [7:0] b, input logic fin);
      text_item_type item;
      item.text_byte  = b;
      item.stream_end = fin;
      text_q.push_back(item);
   endtask

   task automatic add_text(input string s);
      for (int i = 0; i < s.len(); i++) add_byte(s[i], 1'b0);
   endtask

   // Section body byte, biased toward closer characters
   function automatic logic [7:0] pick_body_byte();
      case ($urandom_range(7))
         0: return CHAR_RBRACK;
         1: return CHAR_DASH;
         2: return CHAR_GT;
         3: return CHAR_QUEST;
         4: return CHAR_LT;
         5: return 8'($urandom_range(255));
         default: return 8'h61 + 8'($urandom_range(25)); // lower-case letter
      endcase
   endfunction

   task automatic add_name();
      int len;
      len = $urandom_range(1, 4);
      repeat (len) add_byte(8'h61 + 8'($urandom_range(25)), 1'b0);
   endtask

   task automatic add_body(input int max_len);
      int len;
      len = $urandom_range(0, max_len);
      repeat (len) add_byte(pick_body_byte(), 1'b0);
   endtask

   // Append one markup fragment, mostly well formed
   task automatic add_fragment();
      string         opener;
      int            cut;
      text_item_type item;
      case ($urandom_range(10))
         0, 1: begin
            add_byte(CHAR_LT, 1'b0);
            add_name();
            if ($urandom_range(1)) add_byte(CHAR_SLASH, 1'b0);
            add_byte(CHAR_GT, 1'b0);
         end
         2: begin
            add_text("</");
            add_name();
            add_byte(CHAR_GT, 1'b0);
         end
         3: begin
            add_text("<?");
            add_name();
            add_body(6);
            add_text("?>");
         end
         4: begin
            add_text("<![CDATA[");
            add_body(6);
            add_text("]]>");
         end
         5: begin
            add_text("<!--");
            add_body(6);
            add_text("-->");
         end
         6: add_text("<!-->");
         7, 8: begin
            // truncated opener followed by an arbitrary byte
            if ($urandom_range(1)) begin
               opener = "<![CDATA[";
            end else begin
               opener = "<!--";
            end
            cut = $urandom_range(1, opener.len() - 1);
            add_text(opener.substr(0, cut - 1));
            add_byte(8'($urandom_range(255)), 1'b0);
         end
         9: add_body(8);
         default: repeat ($urandom_range(1, 4)) add_byte(8'($urandom_range(255)), 1'b0);
      endcase
      // occasional stream end, wherever the scanner happens to be
      if ($urandom_range(99) < 4) begin
         item            = text_q.pop_back();
         item.stream_end = 1'b1;
         text_q.push_back(item);
      end
   endtask

   // Offer one byte, idling first at random; hold it until the transfer
   task automatic send_byte(input text_item_type item);
      while ($urandom_range(99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid      <= 1'b1;
      req_if.text_byte  <= item.text_byte;
      req_if.stream_end <= item.stream_end;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
   endtask

   initial begin
      int total;
      req_if.valid      = 1'b0;
      req_if.text_byte  = '0;
      req_if.stream_end = 1'b0;
      send_idle_pct     = 0;
      stall_pct         = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed: reopen on '<', end tag, "<?>" not closing, "<!-->",
      // empty CDATA, byte extremes, two records from one final byte
      add_text("<</<?>?><!--><![CDATA[]]>");
      add_byte(8'h00, 1'b0);
      add_byte(8'hFF, 1'b0);
      add_byte(CHAR_LT, 1'b0);
      add_byte(CHAR_LT, 1'b1);
      while (text_q.size() != 0) send_byte(text_q.pop_front());

      // Random fragments, driven through idling phases
      while (text_q.size() < RANDOM_BYTES) add_fragment();
      total = text_q.size();
      for (int i = 0; i < total; i++) begin
         case (i * 5 / total)
            0: begin send_idle_pct = 0;  stall_pct <= 0;  end
            1: begin send_idle_pct = 56; stall_pct <= 0;  end
            2: begin send_idle_pct = 0;  stall_pct <= 56; end
            3: begin send_idle_pct = 29; stall_pct <= 29; end
            default: begin send_idle_pct = 0; stall_pct <= 0; end
         endcase
         if (i == total / 10) hold_off_go = 1'b1;
         send_byte(text_q.pop_front());
      end
      req_if.valid <= 1'b0;

      // Drain outstanding records
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (fail_count == 0 && pending == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
